FILE: rtl/mlru_pkg.sv
// Shared types and constants for the LRU page replacement core.
`default_nettype none
package mlru_pkg;
    localparam int PAGES = 64;
    localparam int FRAMES = 16;
    localparam int PW = $clog2(PAGES);
    localparam int FW = $clog2(FRAMES);
    localparam int FCW = $clog2(FRAMES + 1);
    localparam logic [16:0] PAGE_SIZE_RESET = 17'd4096;
    localparam logic [4:0] FRAMES_RESET = 5'd16;

    typedef enum logic [0:0] {
        REG_PAGE_SIZE = 1'b0,
        REG_FRAMES = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        OP_READ = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOOKUP,
        ST_SCAN,
        ST_MUL,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic lookup;
        logic scan_start;
        logic scan_step;
        logic mul;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic illegal;
        logic need_scan;
        logic scan_done;
    } status_t;

    typedef struct packed {
        logic [31:0] physical_address;
        logic illegal;
        logic miss;
        logic replaced;
        logic [5:0] victim_page;
        logic wrote_back;
        logic [31:0] fault_count;
        logic [31:0] writeback_count;
    } result_t;
endpackage
`default_nettype wire

FILE: rtl/mlru_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
`default_nettype none
interface mlru_req_if;
    logic valid;
    logic ready;
    logic [31:0] virtual_address;
    logic operation;
    modport source (output valid, virtual_address, operation, input ready);
    modport sink (input valid, virtual_address, operation, output ready);
endinterface

interface mlru_res_if;
    logic valid;
    logic ready;
    logic [31:0] physical_address;
    logic illegal;
    logic miss;
    logic replaced;
    logic [5:0] victim_page;
    logic wrote_back;
    logic [31:0] fault_count;
    logic [31:0] writeback_count;
    modport source (output valid, physical_address, illegal, miss, replaced,
        victim_page, wrote_back, fault_count, writeback_count, input ready);
    modport sink (input valid, physical_address, illegal, miss, replaced,
        victim_page, wrote_back, fault_count, writeback_count, output ready);
endinterface

interface mlru_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/mlru_ctrl.sv
// Controller state machine sequencing divide, lookup, LRU scan and update.
`default_nettype none
module mlru_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire mlru_pkg::status_t status,
    output mlru_pkg::cmd_t        cmd
);
    mlru_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlru_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            mlru_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = mlru_pkg::ST_DIV;
                end
            end
            mlru_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = mlru_pkg::ST_LOOKUP;
            end
            mlru_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (status.illegal)
                    state_next = mlru_pkg::ST_UPDATE;
                else if (status.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = mlru_pkg::ST_SCAN;
                end
                else
                    state_next = mlru_pkg::ST_MUL;
            end
            mlru_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = mlru_pkg::ST_MUL;
            end
            mlru_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = mlru_pkg::ST_UPDATE;
            end
            mlru_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = mlru_pkg::ST_OUT;
            end
            mlru_pkg::ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = mlru_pkg::ST_IDLE;
                end
            end
            default: state_next = mlru_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/mlru_dp.sv
// Datapath: restoring divider, page table, LRU scan, frame multiply, counters.
`default_nettype none
module mlru_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       virtual_address,
    input  wire logic              operation,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire mlru_pkg::cmd_t    cmd,
    output mlru_pkg::status_t      status,
    output mlru_pkg::result_t      result
);
    logic [16:0] page_size_reg;
    logic [4:0] frames_reg;

    logic op_reg;
    logic [16:0] psz_reg;
    logic [31:0] quot_reg;
    logic [16:0] rem_reg;
    logic [5:0] div_cnt_reg;

    logic [mlru_pkg::PAGES-1:0] present_reg;
    logic [mlru_pkg::PAGES-1:0] dirty_reg;
    logic [mlru_pkg::FW-1:0] frame_mem [mlru_pkg::PAGES];
    logic [31:0] stamp_mem [mlru_pkg::PAGES];

    logic [31:0] use_clock_reg;
    logic [mlru_pkg::FCW-1:0] next_free_reg;
    logic [31:0] faults_reg;
    logic [31:0] wbs_reg;

    logic [mlru_pkg::PW-1:0] page_reg;
    logic fault_reg;
    logic illegal_reg;
    logic [mlru_pkg::FW-1:0] frame_reg;
    logic [mlru_pkg::PW:0] scan_idx_reg;
    logic found_reg;
    logic [mlru_pkg::PW-1:0] best_reg;
    logic [31:0] best_stamp_reg;
    logic [31:0] phys_reg;
    logic wb_flag_reg;
    mlru_pkg::result_t res_reg;

    // scan read stage: one table entry per cycle, compared in the following cycle
    logic rd_valid_reg;
    logic rd_present_reg;
    logic [31:0] rd_stamp_reg;
    logic [mlru_pkg::FW-1:0] rd_frame_reg;
    logic [mlru_pkg::PW-1:0] rd_page_reg;

    // restoring division, one quotient bit per cycle
    logic [17:0] trial;
    logic [16:0] rem_shift;
    assign rem_shift = {rem_reg[15:0], quot_reg[31]};
    assign trial = {rem_reg, quot_reg[31]} - {1'b0, psz_reg};

    logic [4:0] flim;
    always_comb
    begin
        if (frames_reg == 5'd0)
            flim = 5'd1;
        else if (frames_reg > 5'(mlru_pkg::FRAMES))
            flim = 5'(mlru_pkg::FRAMES);
        else
            flim = frames_reg;
    end

    logic page_ok;
    assign page_ok = (quot_reg < 32'(mlru_pkg::PAGES));
    logic [mlru_pkg::PW-1:0] scan_i;
    assign scan_i = scan_idx_reg[mlru_pkg::PW-1:0];

    assign status.div_done = (div_cnt_reg == 6'd31);
    assign status.illegal = !page_ok;
    assign status.need_scan = !present_reg[quot_reg[mlru_pkg::PW-1:0]]
        && !(5'(next_free_reg) < flim);
    // last step compares the entry read at index PAGES - 1
    assign status.scan_done = (scan_idx_reg == (mlru_pkg::PW+1)'(mlru_pkg::PAGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= mlru_pkg::PAGE_SIZE_RESET;
            frames_reg <= mlru_pkg::FRAMES_RESET;
            present_reg <= '0;
            dirty_reg <= '0;
            use_clock_reg <= '0;
            next_free_reg <= '0;
            faults_reg <= '0;
            wbs_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (mlru_pkg::reg_idx_t'(cfg_index))
                    mlru_pkg::REG_PAGE_SIZE: page_size_reg <= cfg_data[16:0];
                    mlru_pkg::REG_FRAMES: frames_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (cmd.lookup && page_ok && !present_reg[quot_reg[mlru_pkg::PW-1:0]])
            begin
                faults_reg <= faults_reg + 32'd1;
                if (5'(next_free_reg) < flim)
                    next_free_reg <= next_free_reg + mlru_pkg::FCW'(1);
            end
            if (cmd.mul && fault_reg && found_reg)
            begin
                present_reg[best_reg] <= 1'b0;
                if (dirty_reg[best_reg])
                    wbs_reg <= wbs_reg + 32'd1;
            end
            if (cmd.update && !illegal_reg)
            begin
                present_reg[page_reg] <= 1'b1;
                dirty_reg[page_reg] <= (op_reg == mlru_pkg::OP_WRITE) ||
                    (!fault_reg && dirty_reg[page_reg]);
                use_clock_reg <= use_clock_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            psz_reg <= (page_size_reg == 17'd0) ? 17'd1 : page_size_reg;
            quot_reg <= virtual_address;
            rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
        if (cmd.lookup)
        begin
            page_reg <= quot_reg[mlru_pkg::PW-1:0];
            illegal_reg <= !page_ok;
            fault_reg <= !present_reg[quot_reg[mlru_pkg::PW-1:0]];
            found_reg <= 1'b0;
            best_reg <= '0;
            if (present_reg[quot_reg[mlru_pkg::PW-1:0]])
                frame_reg <= frame_mem[quot_reg[mlru_pkg::PW-1:0]];
            else if (5'(next_free_reg) < flim)
                frame_reg <= next_free_reg[mlru_pkg::FW-1:0];
            else
                frame_reg <= '0;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + (mlru_pkg::PW+1)'(1);
            rd_valid_reg <= !scan_idx_reg[mlru_pkg::PW];
            rd_present_reg <= present_reg[scan_i];
            rd_stamp_reg <= stamp_mem[scan_i];
            rd_frame_reg <= frame_mem[scan_i];
            rd_page_reg <= scan_i;
            if (rd_valid_reg && rd_present_reg
                && (!found_reg || rd_stamp_reg < best_stamp_reg))
            begin
                found_reg <= 1'b1;
                best_reg <= rd_page_reg;
                best_stamp_reg <= rd_stamp_reg;
                frame_reg <= rd_frame_reg;
            end
        end
        if (cmd.mul)
            phys_reg <= 32'(frame_reg) * 32'(psz_reg) + 32'(rem_reg);
        if (cmd.update && !illegal_reg)
        begin
            frame_mem[page_reg] <= frame_reg;
            stamp_mem[page_reg] <= use_clock_reg;
        end
        if (cmd.out_load)
        begin
            res_reg.physical_address <= illegal_reg ? 32'hFFFF_FFFF : phys_reg;
            res_reg.illegal <= illegal_reg;
            res_reg.miss <= !illegal_reg && fault_reg;
            res_reg.replaced <= !illegal_reg && fault_reg && found_reg;
            res_reg.victim_page <= (!illegal_reg && fault_reg && found_reg)
                ? 6'(best_reg) : 6'd0;
            res_reg.wrote_back <= !illegal_reg && fault_reg && found_reg
                && wb_flag_reg;
            res_reg.fault_count <= faults_reg;
            res_reg.writeback_count <= wbs_reg;
        end
    end

    // latch the victim's dirty bit for the result's wrote_back flag
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            wb_flag_reg <= dirty_reg[best_reg];
    end

    assign result = res_reg;
endmodule
`default_nettype wire

FILE: rtl/mmu_lru_page_replacement_core.sv
// Top level of the LRU demand-paging MMU core.
// A hit or a free-frame fault runs the bit-serial divider that splits the address
// into page and offset, then lookup, frame multiply, table update and output load.
// An illegal address skips the multiply. A fault that must evict adds a pass over
// the page table for the oldest stamp before the multiply. The core takes the next
// request in the cycle after a result is loaded. One request is in flight at a time;
// the result register lets the next request enter while a result waits, and a
// result that still waits then holds the core in its output state. Register writes
// are taken at any time but should be made only while the core is idle.
`default_nettype none
module mmu_lru_page_replacement_core (
    input  wire logic clk,
    input  wire logic rst_n,
    mlru_req_if.sink   req,
    mlru_res_if.source res,
    mlru_cfg_if.sink   cfg
);
    mlru_pkg::cmd_t cmd;
    mlru_pkg::status_t status;
    mlru_pkg::result_t result;

    assign cfg.ready = 1'b1;

    mlru_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(req.valid),
        .in_ready(req.ready),
        .out_valid(res.valid),
        .out_ready(res.ready),
        .status(status),
        .cmd(cmd)
    );

    mlru_dp u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .virtual_address(req.virtual_address),
        .operation(req.operation),
        .cfg_we(cfg.valid),
        .cfg_index(cfg.index),
        .cfg_data(cfg.data),
        .cmd(cmd),
        .status(status),
        .result(result)
    );

    assign res.physical_address = result.physical_address;
    assign res.illegal = result.illegal;
    assign res.miss = result.miss;
    assign res.replaced = result.replaced;
    assign res.victim_page = result.victim_page;
    assign res.wrote_back = result.wrote_back;
    assign res.fault_count = result.fault_count;
    assign res.writeback_count = result.writeback_count;
endmodule
`default_nettype wire

FILE: rtl/mlru_checker.sv
// Port-level checker for the LRU page replacement core, bound to the top level.
`default_nettype none
module mlru_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic res_illegal,
    input wire logic res_miss,
    input wire logic res_replaced,
    input wire logic res_wrote_back,
    input wire logic [31:0] res_physical_address,
    input wire logic [5:0] res_victim_page
);
    a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_illegal |-> !res_miss && !res_replaced
            && res_physical_address == 32'hFFFF_FFFF)
        else $error("illegal result carries fault flags");
    a_replace_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_replaced |-> res_miss)
        else $error("replacement without fault");
    a_wb_needs_replace: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_wrote_back |-> res_replaced)
        else $error("writeback without replacement");
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_replaced |-> res_victim_page == 6'd0)
        else $error("victim page set without replacement");
    a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");
endmodule

bind mmu_lru_page_replacement_core mlru_checker u_mlru_checker (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .res_illegal(res.illegal),
    .res_miss(res.miss),
    .res_replaced(res.replaced),
    .res_wrote_back(res.wrote_back),
    .res_physical_address(res.physical_address),
    .res_victim_page(res.victim_page)
);
`default_nettype wire
